// ===== rtl/adn_pkg.sv =====
// shared types and constants for the axis deadzone normalizer
// no dependencies

package adn_pkg;

  localparam int DEF_SAMPLE_WIDTH = 32;
  localparam int FIELD_WIDTH      = 32;
  localparam int PCT_WIDTH        = 7;
  localparam int VALUE_WIDTH      = 8;

  // apb register map
  localparam int DATA_WIDTH = 32;
  localparam int ADDR_WIDTH = 4;
  localparam int IDX_WIDTH  = 2;
  localparam logic [IDX_WIDTH-1:0] REG_MIN = 2'd0;
  localparam logic [IDX_WIDTH-1:0] REG_MAX = 2'd1;
  localparam logic [IDX_WIDTH-1:0] REG_PCT = 2'd2;

  localparam logic [FIELD_WIDTH-1:0] MIN_RESET = 32'hFFFF_8000;
  localparam logic [FIELD_WIDTH-1:0] MAX_RESET = 32'h0000_7FFF;
  localparam logic [PCT_WIDTH-1:0]   PCT_RESET = 7'd10;

  // arithmetic constants
  localparam int DZ_MAX_PCT = 50;
  localparam int DZ_DIV     = 200;
  localparam int DZ_ODD     = 25;
  localparam int DZ_SHIFT   = 3;
  localparam int PCT_SCALE  = 100;
  localparam int QBITS      = 7;
  localparam logic [QBITS-1:0] QMAX = 7'd100;

  // floor(t / 200) for the small remainder term, t < 2^15
  localparam int T_SHW    = 12;
  localparam int T_RSH    = 17;
  localparam int T_RECIP  = 5243;
  localparam int TPROD_W  = 25;

  typedef struct packed {
    logic [FIELD_WIDTH-1:0] axis_minimum;
    logic [FIELD_WIDTH-1:0] axis_maximum;
    logic [PCT_WIDTH-1:0]   deadzone_percent;
  } adn_cfg_t;

  typedef struct packed {
    logic neg;
    logic zero;
    logic invalid;
  } adn_flags_t;

endpackage

// ===== rtl/adn_in_if.sv =====
// sample channel: valid/ready plus raw axis sample
// depends on adn_pkg

interface adn_in_if import adn_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [FIELD_WIDTH-1:0] raw_sample;

  modport source (output valid, output raw_sample, input ready);
  modport sink (input valid, input raw_sample, output ready);
endinterface

// ===== rtl/adn_out_if.sv =====
// result channel: valid/ready plus normalized value and invalid flag
// depends on adn_pkg

interface adn_out_if import adn_pkg::*; ();
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] normalized_value;
  logic                          config_invalid;

  modport source (output valid, output normalized_value, output config_invalid, input ready);
  modport sink (input valid, input normalized_value, input config_invalid, output ready);
endinterface

// ===== rtl/adn_cfg_regs.sv =====
// apb configuration registers: axis minimum, axis maximum, deadzone percent
// depends on adn_pkg

module adn_cfg_regs import adn_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready,
  output adn_cfg_t              cfg
);

  logic [IDX_WIDTH-1:0] idx;
  logic                 wr;

  assign idx    = paddr[ADDR_WIDTH-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.axis_minimum     <= MIN_RESET;
      cfg.axis_maximum     <= MAX_RESET;
      cfg.deadzone_percent <= PCT_RESET;
    end else if (wr) begin
      case (idx)
        REG_MIN: cfg.axis_minimum     <= pwdata;
        REG_MAX: cfg.axis_maximum     <= pwdata;
        REG_PCT: cfg.deadzone_percent <= pwdata[PCT_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MIN: prdata = cfg.axis_minimum;
      REG_MAX: prdata = cfg.axis_maximum;
      REG_PCT: prdata = {{(DATA_WIDTH-PCT_WIDTH){1'b0}}, cfg.deadzone_percent};
      default: prdata = '0;
    endcase
  end

endmodule

// ===== rtl/adn_bounds.sv =====
// front pipeline: clamp, deadzone bounds, region select, scaled numerator
// eight stages with per-stage valid; depends on adn_pkg

module adn_bounds import adn_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  adn_cfg_t                      cfg,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [FIELD_WIDTH-1:0]        sample,
  output logic                          down_valid,
  input  logic                          down_ready,
  output logic [SAMPLE_WIDTH+QBITS-1:0] num,
  output logic [SAMPLE_WIDTH-1:0]       den,
  output adn_flags_t                    flags
);

  localparam int W     = SAMPLE_WIDTH;
  localparam int NW    = W + QBITS;
  localparam int NS    = 8;
  localparam int RS    = W + 2;
  localparam int RW    = W - 2;
  localparam int PW    = 2 * W - 5;
  localparam int QW    = W - 7;
  localparam logic [63:0] RECIP_FULL = ((64'd1 << RS) + 64'(DZ_ODD - 1)) / 64'(DZ_ODD);
  localparam logic [RW-1:0] RECIP = RECIP_FULL[RW-1:0];

  logic [NS:1]   v;
  logic [NS+1:1] adv;

  logic signed [W-1:0] lo_s, hi_s, x_s;
  logic [PCT_WIDTH-1:0] pct;

  assign lo_s = cfg.axis_minimum[W-1:0];
  assign hi_s = cfg.axis_maximum[W-1:0];
  assign pct  = cfg.deadzone_percent;
  assign x_s  = sample[W-1:0];

  always_comb begin
    adv[NS+1] = down_ready;
    for (int k = NS; k >= 1; k--) begin
      adv[k] = !v[k] || adv[k+1];
    end
  end

  assign up_ready   = adv[1];
  assign down_valid = v[NS];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (adv[1]) begin
        v[1] <= up_valid;
      end
      for (int k = 2; k <= NS; k++) begin
        if (adv[k]) begin
          v[k] <= v[k-1];
        end
      end
    end
  end

  // stage 1: validity, clamp, span
  logic                s1_inv;
  logic signed [W-1:0] s1_x;
  logic [W-1:0]        s1_span;
  logic [W:0]          span_w;
  logic signed [W-1:0] xc;

  assign span_w = {hi_s[W-1], hi_s} - {lo_s[W-1], lo_s};

  always_comb begin
    xc = x_s;
    if (x_s < lo_s) begin
      xc = lo_s;
    end else if (x_s > hi_s) begin
      xc = hi_s;
    end
  end

  always_ff @(posedge clk) begin
    if (adv[1]) begin
      s1_inv  <= (hi_s <= lo_s) || (pct > PCT_WIDTH'(DZ_MAX_PCT));
      s1_x    <= xc;
      s1_span <= span_w[W-1:0];
    end
  end

  // stage 2: span / 200 by reciprocal multiply
  logic                s2_inv;
  logic signed [W-1:0] s2_x;
  logic [W-1:0]        s2_span;
  logic [PW-1:0]       s2_prod;

  always_ff @(posedge clk) begin
    if (adv[2]) begin
      s2_inv  <= s1_inv;
      s2_x    <= s1_x;
      s2_span <= s1_span;
      s2_prod <= PW'(s1_span[W-1:DZ_SHIFT]) * PW'(RECIP);
    end
  end

  // stage 3: quotient and remainder of span / 200
  logic                s3_inv;
  logic signed [W-1:0] s3_x;
  logic [W-1:0]        s3_span;
  logic [QW-1:0]       s3_qs;
  logic [7:0]          s3_rs;
  logic [QW-1:0]       qs;
  logic [W-1:0]        rs_w;

  assign qs   = s2_prod[PW-1:RS];
  assign rs_w = s2_span - W'(qs) * W'(DZ_DIV);

  always_ff @(posedge clk) begin
    if (adv[3]) begin
      s3_inv  <= s2_inv;
      s3_x    <= s2_x;
      s3_span <= s2_span;
      s3_qs   <= qs;
      s3_rs   <= rs_w[7:0];
    end
  end

  // stage 4: partial products of span * pct
  logic                s4_inv;
  logic signed [W-1:0] s4_x;
  logic [W-1:0]        s4_span;
  logic [W-1:0]        s4_hq;
  logic [14:0]         s4_t;

  always_ff @(posedge clk) begin
    if (adv[4]) begin
      s4_inv  <= s3_inv;
      s4_x    <= s3_x;
      s4_span <= s3_span;
      s4_hq   <= W'(s3_qs) * W'(pct);
      s4_t    <= 15'(s3_rs) * 15'(pct);
    end
  end

  // stage 5: half deadzone
  logic                s5_inv;
  logic signed [W-1:0] s5_x;
  logic [W-1:0]        s5_span;
  logic [W-1:0]        s5_half;
  logic [TPROD_W-1:0]  tprod;

  assign tprod = TPROD_W'(s4_t[14:DZ_SHIFT]) * TPROD_W'(T_RECIP);

  always_ff @(posedge clk) begin
    if (adv[5]) begin
      s5_inv  <= s4_inv;
      s5_x    <= s4_x;
      s5_span <= s4_span;
      s5_half <= s4_hq + W'(tprod[TPROD_W-1:T_RSH]);
    end
  end

  // stage 6: deadzone edges
  logic                s6_inv;
  logic signed [W-1:0] s6_x;
  logic signed [W-1:0] s6_low;
  logic signed [W-1:0] s6_high;
  logic [W+1:0]        ctr_w, low_w, high_w;

  assign ctr_w  = {{2{lo_s[W-1]}}, lo_s} + {3'b000, s5_span[W-1:1]};
  assign low_w  = ctr_w - {2'b00, s5_half};
  assign high_w = ctr_w + {2'b00, s5_half};

  always_ff @(posedge clk) begin
    if (adv[6]) begin
      s6_inv  <= s5_inv;
      s6_x    <= s5_x;
      s6_low  <= low_w[W-1:0];
      s6_high <= high_w[W-1:0];
    end
  end

  // stage 7: region, distance and denominator
  adn_flags_t   s7_flags;
  logic [W-1:0] s7_d;
  logic [W-1:0] s7_den;
  logic         lt, gt;
  logic [W:0]   d_lo, den_lo, d_hi, den_hi;

  assign lt     = s6_x < s6_low;
  assign gt     = s6_x > s6_high;
  assign d_lo   = {s6_low[W-1], s6_low} - {s6_x[W-1], s6_x};
  assign den_lo = {s6_low[W-1], s6_low} - {lo_s[W-1], lo_s};
  assign d_hi   = {s6_x[W-1], s6_x} - {s6_high[W-1], s6_high};
  assign den_hi = {hi_s[W-1], hi_s} - {s6_high[W-1], s6_high};

  always_ff @(posedge clk) begin
    if (adv[7]) begin
      s7_flags.neg     <= lt;
      s7_flags.zero    <= !lt && !gt;
      s7_flags.invalid <= s6_inv;
      s7_d             <= lt ? d_lo[W-1:0] : d_hi[W-1:0];
      s7_den           <= lt ? den_lo[W-1:0] : den_hi[W-1:0];
    end
  end

  // stage 8: numerator scaled to percent
  always_ff @(posedge clk) begin
    if (adv[8]) begin
      flags <= s7_flags;
      den   <= s7_den;
      num   <= NW'(s7_d) * NW'(PCT_SCALE);
    end
  end

endmodule

// ===== rtl/adn_div_cell.sv =====
// one restoring-division cell: resolves a single quotient bit per item
// depends on adn_pkg

module adn_div_cell import adn_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
  parameter int SHIFT        = 0
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  logic [SAMPLE_WIDTH+QBITS-1:0] rem_in,
  input  logic [SAMPLE_WIDTH-1:0]       den_in,
  input  logic [QBITS-1:0]              q_in,
  input  adn_flags_t                    flags_in,
  output logic                          down_valid,
  input  logic                          down_ready,
  output logic [SAMPLE_WIDTH+QBITS-1:0] rem_out,
  output logic [SAMPLE_WIDTH-1:0]       den_out,
  output logic [QBITS-1:0]              q_out,
  output adn_flags_t                    flags_out
);

  localparam int NW = SAMPLE_WIDTH + QBITS;

  logic          v;
  logic [NW:0]   trial;
  logic          ge;
  logic [QBITS-1:0] q_next;

  assign up_ready   = !v || down_ready;
  assign down_valid = v;

  assign trial = {1'b0, rem_in} - {1'b0, NW'(den_in) << SHIFT};
  assign ge    = !trial[NW];

  always_comb begin
    q_next        = q_in;
    q_next[SHIFT] = ge;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= 1'b0;
    end else if (up_ready) begin
      v <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      rem_out   <= ge ? trial[NW-1:0] : rem_in;
      den_out   <= den_in;
      q_out     <= q_next;
      flags_out <= flags_in;
    end
  end

endmodule

// ===== rtl/axis_deadzone_normalize.sv =====
// axis deadzone normalizer: throughput one item per clock unless results.ready stalls the
// output; the 8-stage bounds pipeline feeds a row of 7
// division cells, one quotient bit each, then an output register
// synchronous active-high reset clears all valid bits and loads register defaults
// depends on adn_pkg, adn_in_if, adn_out_if, adn_cfg_regs, adn_bounds, adn_div_cell

module axis_deadzone_normalize import adn_pkg::*; #(
  parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  adn_in_if.sink                samples,
  adn_out_if.source             results,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [ADDR_WIDTH-1:0] paddr,
  input  logic [DATA_WIDTH-1:0] pwdata,
  output logic [DATA_WIDTH-1:0] prdata,
  output logic                  pready
);

  localparam int W  = SAMPLE_WIDTH;
  localparam int NW = W + QBITS;

  adn_cfg_t cfg;

  adn_cfg_regs u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  logic             c_valid [0:QBITS];
  logic             c_ready [0:QBITS];
  logic [NW-1:0]    c_rem   [0:QBITS];
  logic [W-1:0]     c_den   [0:QBITS];
  logic [QBITS-1:0] c_q     [0:QBITS];
  adn_flags_t       c_flags [0:QBITS];

  adn_bounds #(.SAMPLE_WIDTH(W)) u_bounds (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .up_valid   (samples.valid),
    .up_ready   (samples.ready),
    .sample     (samples.raw_sample),
    .down_valid (c_valid[0]),
    .down_ready (c_ready[0]),
    .num        (c_rem[0]),
    .den        (c_den[0]),
    .flags      (c_flags[0])
  );

  assign c_q[0] = '0;

  for (genvar i = 0; i < QBITS; i++) begin : g_cell
    adn_div_cell #(.SAMPLE_WIDTH(W), .SHIFT(QBITS - 1 - i)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (c_valid[i]),
      .up_ready   (c_ready[i]),
      .rem_in     (c_rem[i]),
      .den_in     (c_den[i]),
      .q_in       (c_q[i]),
      .flags_in   (c_flags[i]),
      .down_valid (c_valid[i+1]),
      .down_ready (c_ready[i+1]),
      .rem_out    (c_rem[i+1]),
      .den_out    (c_den[i+1]),
      .q_out      (c_q[i+1]),
      .flags_out  (c_flags[i+1])
    );
  end

  // output register
  logic                          res_v;
  logic signed [VALUE_WIDTH-1:0] res_val;
  logic                          res_inv;
  logic                          adv_o;
  logic signed [VALUE_WIDTH-1:0] mag;
  logic signed [VALUE_WIDTH-1:0] val_next;
  adn_flags_t                    fl;

  assign fl    = c_flags[QBITS];
  assign adv_o = !res_v || results.ready;
  assign c_ready[QBITS] = adv_o;
  assign mag   = {1'b0, c_q[QBITS]};

  always_comb begin
    if (fl.invalid || fl.zero) begin
      val_next = '0;
    end else if (fl.neg) begin
      val_next = -mag;
    end else begin
      val_next = mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_v <= 1'b0;
    end else if (adv_o) begin
      res_v <= c_valid[QBITS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_o) begin
      res_val <= val_next;
      res_inv <= fl.invalid;
    end
  end

  assign results.valid            = res_v;
  assign results.normalized_value = res_val;
  assign results.config_invalid   = res_inv;

  a_range: assert property (@(posedge clk) disable iff (rst)
    res_v |-> (res_val <= 8'sd100 && res_val >= -8'sd100))
    else $error("normalized value out of range");

  a_inv_zero: assert property (@(posedge clk) disable iff (rst)
    (res_v && res_inv) |-> (res_val == '0))
    else $error("invalid config result not zero");

  a_quot: assert property (@(posedge clk) disable iff (rst)
    (c_valid[QBITS] && !fl.invalid && !fl.zero) |-> (c_q[QBITS] <= QMAX))
    else $error("quotient above full scale");

  a_pct_wr: assert property (@(posedge clk) disable iff (rst)
    (psel && penable && pwrite && paddr[ADDR_WIDTH-1:2] == REG_PCT)
      |=> (cfg.deadzone_percent == $past(pwdata[PCT_WIDTH-1:0])))
    else $error("deadzone register write lost");

endmodule
